### rtl/cdad_pkg.sv
// Package: widths, calendar step tables and state codes for the date adder.
`timescale 1ns / 1ps
`default_nettype none

package cdad_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned OffsetW = 21;
  localparam int unsigned DaysW   = 24;
  localparam int unsigned StepW   = 18;
  localparam int unsigned DoyW    = 9;
  localparam int unsigned MaxYear = 9999;

  localparam logic [MonthW-1:0] MpFeb   = 4'd11;
  localparam logic [MonthW-1:0] MpJan   = 4'd10;
  localparam logic [1:0]        StepEra = 2'd0;
  localparam logic [1:0]        StepCen = 2'd1;
  localparam logic [1:0]        StepQy  = 2'd2;
  localparam logic [1:0]        StepYr  = 2'd3;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENC  = 3'd1;
  localparam logic [2:0] S_DOY  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_MON  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  function automatic logic [YearW-1:0] year_step(input logic [1:0] k);
    logic [YearW-1:0] v;
    unique case (k)
      StepEra: v = 14'd400;
      StepCen: v = 14'd100;
      StepQy:  v = 14'd4;
      StepYr:  v = 14'd1;
      default: v = 14'd1;
    endcase
    return v;
  endfunction

  function automatic logic [StepW-1:0] day_step(input logic [1:0] k);
    logic [StepW-1:0] v;
    unique case (k)
      StepEra: v = 18'd146097;
      StepCen: v = 18'd36524;
      StepQy:  v = 18'd1461;
      StepYr:  v = 18'd365;
      default: v = 18'd365;
    endcase
    return v;
  endfunction

  // day of year at the first of each month, year starting in March
  function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] mp);
    logic [DoyW-1:0] v;
    unique case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mp);
    logic [DayW-1:0] v;
    unique case (mp)
      4'd1, 4'd3, 4'd6, 4'd8: v = 5'd30;
      4'd11:                  v = 5'd29;
      default:                v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/calendar_date_add_days_unit.sv
// Top level: Gregorian date plus signed day offset on one shared 24-bit adder.
//
// Channel | Direction | Handshake          | Beat
// --------+-----------+--------------------+------------------------------------------
// command | in        | start && !busy     | start_year_i, start_month_i, start_day_i,
//         |           |                    | day_offset_i
// result  | out       | done_o (one cycle) | result_year_o, result_month_o,
//         |           |                    | result_day_o, out_of_range_o
//
// A beat with an invalid start year goes straight to the finish state; else its length is
// set by the era/century/four-year/year loops that encode and then decode the day
// count and by the month walk, each one add or subtract per cycle on the adder.
// busy is high from the accepted beat until done_o; start is ignored meanwhile.
// rst_ni clears the sequencer and the strobe asynchronously; nothing to initialize.
// The receiver cannot stall: done_o is high for exactly one cycle per beat.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_add_days_unit
  import cdad_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [YearW-1:0]          start_year_i,
  input  wire logic [MonthW-1:0]         start_month_i,
  input  wire logic [DayW-1:0]           start_day_i,
  input  wire logic signed [OffsetW-1:0] day_offset_i,
  output logic                           done_o,
  output logic [YearW-1:0]               result_year_o,
  output logic [MonthW-1:0]              result_month_o,
  output logic [DayW-1:0]                result_day_o,
  output logic                           out_of_range_o
);

  logic [2:0]        state_q, state_d;
  logic [1:0]        k_q, k_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [MonthW-1:0] mp_q, mp_d;
  logic [YearW-1:0]  yy_q, yy_d;
  logic [YearW-1:0]  yr_q, yr_d;
  logic [DaysW-1:0]  z_q, z_d;
  logic              bad_q, bad_d;
  logic [YearW-1:0]  in_y_q;
  logic [MonthW-1:0] in_m_q;
  logic [DayW-1:0]   in_d_q;

  logic              done_d;
  logic [YearW-1:0]  res_y_d;
  logic [MonthW-1:0] res_m_d;
  logic [DayW-1:0]   res_d_d;
  logic              res_bad_d;

  logic [DaysW-1:0]  add_a, add_b;
  logic              add_sub;
  logic [DaysW:0]    add_sum;
  logic              add_carry;

  logic [YearW-1:0]  ny;
  logic [MonthW-1:0] nm;
  logic [YearW-1:0]  ystep;
  logic [DaysW-1:0]  dstep;
  logic signed [9:0] doy_adj;
  logic              capped;
  logic [YearW:0]    fin_year;

  assign ystep   = year_step(k_q);
  assign dstep   = {{(DaysW-StepW){1'b0}}, day_step(k_q)};
  assign doy_adj = $signed({1'b0, month_start(mp_q)}) + $signed({5'b0, in_d_q})
                   - 10'sd1;
  assign capped  = (k_q == StepCen) || (k_q == StepYr);

  // shared adder: add or subtract with carry out as the no-borrow flag
  always_comb begin
    add_a   = z_q;
    add_b   = dstep;
    add_sub = 1'b0;
    unique case (state_q)
      S_DOY: add_b = {{(DaysW-10){doy_adj[9]}}, doy_adj};
      S_DEC: add_sub = 1'b1;
      S_MON: begin
        add_b   = {{(DaysW-DayW){1'b0}}, month_len(mp_q)};
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_sum   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                     + {{DaysW{1'b0}}, add_sub};
  assign add_carry = add_sum[DaysW];

  // fold month zero and months above twelve into the year
  always_comb begin
    ny = start_year_i;
    nm = start_month_i;
    if (start_month_i == 4'd0) begin
      nm = 4'd12;
      ny = start_year_i - 14'd1;
    end else if (start_month_i > 4'd12) begin
      nm = start_month_i - 4'd12;
      ny = start_year_i + 14'd1;
    end
  end

  assign fin_year = {1'b0, yr_q} + {{YearW{1'b0}}, (mp_q >= MpJan)};

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    mp_d      = mp_q;
    yy_d      = yy_q;
    yr_d      = yr_q;
    z_d       = z_q;
    bad_d     = bad_q;
    done_d    = 1'b0;
    res_y_d   = in_y_q;
    res_m_d   = in_m_q;
    res_d_d   = in_d_q;
    res_bad_d = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          k_d   = StepEra;
          z_d   = {{(DaysW-OffsetW){day_offset_i[OffsetW-1]}}, day_offset_i};
          mp_d  = (nm >= 4'd3) ? nm - 4'd3 : nm + 4'd9;
          yy_d  = ny - {{(YearW-1){1'b0}}, (nm <= 4'd2)};
          bad_d = (start_year_i == '0) || (start_year_i > YearW'(MaxYear));
          state_d = bad_d ? S_FIN : S_ENC;
        end
      end
      S_ENC: begin
        if (yy_q >= ystep) begin
          yy_d = yy_q - ystep;
          z_d  = add_sum[DaysW-1:0];
        end else if (k_q == StepYr) begin
          state_d = S_DOY;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_DOY: begin
        z_d     = add_sum[DaysW-1:0];
        k_d     = StepEra;
        cnt_d   = '0;
        yr_d    = '0;
        state_d = S_DEC;
      end
      S_DEC: begin
        if (z_q[DaysW-1]) begin
          bad_d   = 1'b1;
          state_d = S_FIN;
        end else if (add_carry && !(capped && cnt_q == 2'd3)) begin
          z_d   = add_sum[DaysW-1:0];
          yr_d  = yr_q + ystep;
          cnt_d = cnt_q + 2'd1;
        end else begin
          cnt_d = '0;
          if (k_q == StepYr) begin
            mp_d    = '0;
            state_d = S_MON;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      S_MON: begin
        if (add_carry && mp_q != MpFeb) begin
          z_d  = add_sum[DaysW-1:0];
          mp_d = mp_q + 4'd1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (!bad_q && fin_year != '0 && fin_year <= (YearW+1)'(MaxYear)) begin
          res_y_d   = fin_year[YearW-1:0];
          res_m_d   = (mp_q < MpJan) ? mp_q + 4'd3 : mp_q - 4'd9;
          res_d_d   = z_q[DayW-1:0] + 5'd1;
          res_bad_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    cnt_q <= cnt_d;
    mp_q  <= mp_d;
    yy_q  <= yy_d;
    yr_q  <= yr_d;
    z_q   <= z_d;
    bad_q <= bad_d;
    if (state_q == S_IDLE && start) begin
      in_y_q <= start_year_i;
      in_m_q <= start_month_i;
      in_d_q <= start_day_i;
    end
    if (done_d) begin
      result_year_o  <= res_y_d;
      result_month_o <= res_m_d;
      result_day_o   <= res_d_d;
      out_of_range_o <= res_bad_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_month_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_of_range_o) |->
      (result_month_o >= 4'd1 && result_month_o <= 4'd12 && result_day_o != 5'd0))
    else $error("invalid month or day in result");

  a_year_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_of_range_o) |->
      (result_year_o != '0 && result_year_o <= YearW'(MaxYear)))
    else $error("result year out of range without flag");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MON) |-> (mp_q <= MpFeb && !z_q[DaysW-1]))
    else $error("month walk out of bounds");

endmodule

`default_nettype wire

### bench/calendar_date_add_days_unit_test.sv
// Testbench: directed and random date-plus-offset beats, checked by table or predictor.
`timescale 1ns / 1ps

module calendar_date_add_days_unit_test
  import cdad_pkg::*;
();

  localparam int NumBeats   = 1350;
  localparam int QuietTail  = 150;
  localparam int DrainAt    = 700;
  localparam int CycleLimit = 1000000;
  localparam int TailCycles = 200;
  localparam longint DayBiasYears = 4000;

  typedef struct {
    logic [YearW-1:0]          year;
    logic [MonthW-1:0]         month;
    logic [DayW-1:0]           day;
    logic signed [OffsetW-1:0] offset;
  } date_beat_t;

  typedef struct {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              oor;
  } date_result_t;

  typedef struct {
    date_beat_t   cmd;
    bit           typed;
    date_result_t want;
  } date_case_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [YearW-1:0]          start_year_i = '0;
  logic [MonthW-1:0]         start_month_i = '0;
  logic [DayW-1:0]           start_day_i = '0;
  logic signed [OffsetW-1:0] day_offset_i = '0;
  logic                      done_o;
  logic [YearW-1:0]          result_year_o;
  logic [MonthW-1:0]         result_month_o;
  logic [DayW-1:0]           result_day_o;
  logic                      out_of_range_o;

  date_result_t pending_dates[$];
  int           mismatches = 0;

  date_case_t date_cases [26] = '{
    '{'{2024, 2, 28, 1},        1, '{2024, 2, 29, 0}},
    '{'{2023, 2, 28, 1},        1, '{2023, 3, 1, 0}},
    '{'{1900, 2, 28, 1},        1, '{1900, 3, 1, 0}},
    '{'{2000, 2, 28, 1},        1, '{2000, 2, 29, 0}},
    '{'{2024, 3, 1, -1},        1, '{2024, 2, 29, 0}},
    '{'{2023, 12, 31, 1},       1, '{2024, 1, 1, 0}},
    '{'{1, 1, 1, 0},            1, '{1, 1, 1, 0}},
    '{'{9999, 12, 31, 0},       1, '{9999, 12, 31, 0}},
    '{'{9999, 12, 31, 1},       1, '{9999, 12, 31, 1}},
    '{'{1, 1, 1, -1},           1, '{1, 1, 1, 1}},
    '{'{0, 5, 10, 0},           1, '{0, 5, 10, 1}},
    '{'{10000, 1, 1, 0},        1, '{10000, 1, 1, 1}},
    '{'{16383, 15, 31, -1},     1, '{16383, 15, 31, 1}},
    '{'{2023, 0, 15, 0},        1, '{2022, 12, 15, 0}},
    '{'{2023, 15, 31, 0},       1, '{2024, 3, 31, 0}},
    '{'{2023, 13, 0, 0},        1, '{2023, 12, 31, 0}},
    '{'{2023, 2, 31, 0},        1, '{2023, 3, 3, 0}},
    '{'{2023, 4, 0, 0},         1, '{2023, 3, 31, 0}},
    '{'{1, 0, 1, 0},            1, '{1, 0, 1, 1}},
    '{'{9999, 13, 1, 0},        1, '{9999, 13, 1, 1}},
    '{'{1, 1, 1, -1048576},     1, '{1, 1, 1, 1}},
    '{'{9999, 1, 1, 1048575},   1, '{9999, 1, 1, 1}},
    '{'{5000, 6, 15, 1048575},  0, '{0, 0, 0, 0}},
    '{'{5000, 6, 15, -1048576}, 0, '{0, 0, 0, 0}},
    '{'{1, 1, 1, 1048575},      0, '{0, 0, 0, 0}},
    '{'{9999, 12, 31, -1048576}, 0, '{0, 0, 0, 0}}
  };

  calendar_date_add_days_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .start_year_i   (start_year_i),
    .start_month_i  (start_month_i),
    .start_day_i    (start_day_i),
    .day_offset_i   (day_offset_i),
    .done_o         (done_o),
    .result_year_o  (result_year_o),
    .result_month_o (result_month_o),
    .result_day_o   (result_day_o),
    .out_of_range_o (out_of_range_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic date_result_t add_days(input date_beat_t b);
    date_result_t r;
    longint yr, mo, span, era, yoe, mp, doy, doe;
    r.year  = b.year;
    r.month = b.month;
    r.day   = b.day;
    r.oor   = 1'b1;
    yr = longint'(b.year);
    mo = longint'(b.month);
    if (yr < 1 || yr > longint'(MaxYear)) return r;
    if (mo == 0) begin
      mo = 12;
      yr = yr - 1;
    end else if (mo > 12) begin
      mo = mo - 12;
      yr = yr + 1;
    end
    // count days from a biased epoch, year taken to start in March
    yr = yr + DayBiasYears;
    if (mo <= 2) yr = yr - 1;
    era  = yr / 400;
    yoe  = yr - era * 400;
    mp   = (mo + 9) % 12;
    doy  = (153 * mp + 2) / 5;
    span = era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy
         + longint'(b.day) - 1 + longint'(b.offset);
    if (span < 0) return r;
    era = span / 146097;
    doe = span - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    mo  = (mp < 10) ? mp + 3 : mp - 9;
    yr  = yoe + era * 400 + longint'(mo <= 2) - DayBiasYears;
    if (yr < 1 || yr > longint'(MaxYear)) return r;
    r.year  = YearW'(yr);
    r.month = MonthW'(mo);
    r.day   = DayW'(doy - (153 * mp + 2) / 5 + 1);
    r.oor   = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  // drive one beat after the idle gap given by gap, hold until accepted, drop start if asked
  task automatic send_date(input date_beat_t b, input date_result_t want, input int gap,
                           input bit drop);
    repeat (gap) @(posedge clk_i);
    start         <= 1'b1;
    start_year_i  <= b.year;
    start_month_i <= b.month;
    start_day_i   <= b.day;
    day_offset_i  <= b.offset;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_dates.push_back(want);
    if (drop) start <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    date_result_t want;
    if (rst_ni && done_o) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result year", 0, result_year_o);
      end else begin
        want = pending_dates.pop_front();
        if (result_year_o !== want.year)
          report_mismatch("year", want.year, result_year_o);
        if (result_month_o !== want.month)
          report_mismatch("month", want.month, result_month_o);
        if (result_day_o !== want.day)
          report_mismatch("day", want.day, result_day_o);
        if (out_of_range_o !== want.oor)
          report_mismatch("out_of_range", want.oor, out_of_range_o);
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  initial begin
    date_beat_t   cmd;
    date_result_t want;
    int           gap, next_gap, sel, kind, t, mlen;
    bit           leap, drain;
    gap = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumBeats; i++) begin
      if (i < $size(date_cases)) begin
        cmd  = date_cases[5'(i)].cmd;
        want = date_cases[5'(i)].typed ? date_cases[5'(i)].want : add_days(cmd);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 8) cmd.year = YearW'($urandom_range(1, 5));
        else if (sel < 16) cmd.year = YearW'($urandom_range(9995, 9999));
        else cmd.year = YearW'($urandom_range(1, 9999));
        cmd.month = MonthW'($urandom_range(1, 12));
        leap = (cmd.year % 4 == 0 && cmd.year % 100 != 0) || cmd.year % 400 == 0;
        case (cmd.month)
          4'd2: begin
            mlen = leap ? 29 : 28;
          end
          4'd4, 4'd6, 4'd9, 4'd11: begin
            mlen = 30;
          end
          default: begin
            mlen = 31;
          end
        endcase
        cmd.day = DayW'($urandom_range(1, mlen));
        if ($urandom_range(0, 9) == 0) begin
          cmd.month = MonthW'($urandom_range(0, 15));
          cmd.day   = DayW'($urandom_range(0, 31));
          if ($urandom_range(0, 2) == 0) cmd.year = YearW'($urandom_range(0, 16383));
        end
        kind = $urandom_range(0, 9);
        if (kind < 4) t = $urandom_range(0, 80) - 40;
        else if (kind < 6) t = $urandom_range(0, 1) ? 1 : -1;
        else if (kind < 8) t = $urandom_range(0, 6000) - 3000;
        else t = $urandom;
        cmd.offset = t[OffsetW-1:0];
        want = add_days(cmd);
      end
      drain = (i + 1 == DrainAt);
      if (i + 1 >= NumBeats - QuietTail || ((i + 1) / 50) % 3 == 2) next_gap = 0;
      else next_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
      send_date(cmd, want, gap, next_gap != 0 || drain || i + 1 == NumBeats);
      if (drain) begin
        wait (pending_dates.size() == 0);
        @(posedge clk_i);
      end
      gap = next_gap;
    end
    wait (pending_dates.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### calendar_date_add_days_unit.f
rtl/cdad_pkg.sv
rtl/calendar_date_add_days_unit.sv
bench/calendar_date_add_days_unit_test.sv
